// ===== src/tcse_pkg.sv =====
`timescale 1ns / 1ps

package tcse_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;

  localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'h20;
  localparam logic [COLOR_W-1:0] WHITE        = 4'hF;
  localparam logic [COLOR_W-1:0] BLACK        = 4'h0;

  typedef enum logic [OP_W-1:0] {
    OP_PUT      = 2'd0,
    OP_SET_FILL = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_READ     = 2'd3
  } tcse_op_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_READ
  } tcse_ctl_state_t;

  typedef enum logic [1:0] {
    SWEEP_IDLE,
    SWEEP_FILL,
    SWEEP_COPY
  } tcse_sweep_t;

  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic [CHAR_W-1:0]  ch;
  } tcse_cell_t;

  // fill colour: background in the high nibble, foreground in the low
  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
  } tcse_color_t;

  typedef struct packed {
    logic       start_fill;
    logic       start_scroll;
    tcse_cell_t fill_cell;
  } tcse_store_cmd_t;

  localparam tcse_cell_t RESET_CELL = '{bg: BLACK, fg: WHITE, ch: BLANK_CODE};

  function automatic tcse_cell_t blank_cell(tcse_color_t color);
    tcse_cell_t c;
    c.bg = color.bg;
    c.fg = color.fg;
    c.ch = BLANK_CODE;
    return c;
  endfunction

endpackage

// ===== src/tcse_in_if.sv =====
`timescale 1ns / 1ps

interface tcse_in_if;
  logic                            valid;
  logic                            ready;
  logic [tcse_pkg::OP_W-1:0]       operation;
  logic [tcse_pkg::CHAR_W-1:0]     char_code;
  logic [tcse_pkg::COLOR_W-1:0]    fg_color;
  logic [tcse_pkg::COLOR_W-1:0]    bg_color;
  logic [tcse_pkg::COL_W-1:0]      cell_column;
  logic [tcse_pkg::ROW_W-1:0]      cell_row;

  modport source (
    output valid, operation, char_code, fg_color, bg_color, cell_column, cell_row,
    input  ready
  );

  modport sink (
    input  valid, operation, char_code, fg_color, bg_color, cell_column, cell_row,
    output ready
  );
endinterface

// ===== src/tcse_out_if.sv =====
`timescale 1ns / 1ps

interface tcse_out_if;
  logic                            valid;
  logic                            ready;
  logic [tcse_pkg::CHAR_W-1:0]     read_char;
  logic [tcse_pkg::COLOR_W-1:0]    read_fg;
  logic [tcse_pkg::COLOR_W-1:0]    read_bg;
  logic [tcse_pkg::ROW_W-1:0]      cursor_row_now;
  logic [tcse_pkg::COL_W-1:0]      cursor_column_now;
  logic                            out_of_range;

  modport source (
    output valid, read_char, read_fg, read_bg, cursor_row_now, cursor_column_now,
           out_of_range,
    input  ready
  );

  modport sink (
    input  valid, read_char, read_fg, read_bg, cursor_row_now, cursor_column_now,
           out_of_range,
    output ready
  );
endinterface

// ===== src/tcse_cell_store.sv =====
`timescale 1ns / 1ps

module tcse_cell_store #(
  parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcse_pkg::ROWS_DEF,
  localparam int TOTAL  = ROWS * COLUMNS,
  localparam int ADDR_W = $clog2(TOTAL)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tcse_pkg::tcse_store_cmd_t cmd,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  tcse_pkg::tcse_cell_t      wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output tcse_pkg::tcse_cell_t      rd_data,
  output logic                      busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(TOTAL - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);

  tcse_pkg::tcse_cell_t mem [TOTAL];
  tcse_pkg::tcse_cell_t rdata_r;

  tcse_pkg::tcse_sweep_t sweep_r, sweep_nxt;
  logic [ADDR_W-1:0]     cnt_r, cnt_nxt;
  tcse_pkg::tcse_cell_t  fill_cell_r, fill_cell_nxt;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  tcse_pkg::tcse_cell_t  mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= tcse_pkg::SWEEP_FILL;
      cnt_r       <= '0;
      fill_cell_r <= tcse_pkg::RESET_CELL;
    end else begin
      sweep_r     <= sweep_nxt;
      cnt_r       <= cnt_nxt;
      fill_cell_r <= fill_cell_nxt;
    end
  end

  always_comb begin
    sweep_nxt     = sweep_r;
    cnt_nxt       = cnt_r;
    fill_cell_nxt = fill_cell_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_addr;
    mem_wdata     = wr_data;
    mem_re        = 1'b0;
    mem_raddr     = rd_addr;
    unique case (sweep_r)
      tcse_pkg::SWEEP_IDLE: begin
        mem_we = wr_en;
        mem_re = rd_en;
        priority if (cmd.start_fill) begin
          fill_cell_nxt = cmd.fill_cell;
          cnt_nxt       = '0;
          sweep_nxt     = tcse_pkg::SWEEP_FILL;
        end else if (cmd.start_scroll) begin
          fill_cell_nxt = cmd.fill_cell;
          cnt_nxt       = '0;
          sweep_nxt     = tcse_pkg::SWEEP_COPY;
        end
      end
      tcse_pkg::SWEEP_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = fill_cell_r;
        if (cnt_r == LAST_ADDR) begin
          sweep_nxt = tcse_pkg::SWEEP_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tcse_pkg::SWEEP_COPY: begin
        // read one row ahead, write back what the previous cycle fetched
        if (cnt_r != COPY_END) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r + ROW_STEP;
        end
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r - 1'b1;
          mem_wdata = rdata_r;
        end
        if (cnt_r == COPY_END) begin
          // bottom row starts at COPY_END: blank it next
          sweep_nxt = tcse_pkg::SWEEP_FILL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: sweep_nxt = tcse_pkg::SWEEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign rd_data = rdata_r;
  assign busy    = (sweep_r != tcse_pkg::SWEEP_IDLE);

endmodule

// ===== src/text_console_scroll_engine.sv =====
`timescale 1ns / 1ps
// Put, set fill colour and clear: result loaded into the output register when the item is accepted.
// Read cell: result via the cell store read register, then the output register; input waits.
// Throughput: one put per cycle unless the store is busy or the output stalls.
// Clear blocks input for a fill sweep, a scroll for a row copy sweep then a bottom-row fill.
// Reset: synchronous; afterwards a clearing pass blanks the store.
module text_console_scroll_engine #(
  parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcse_pkg::ROWS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  tcse_in_if.sink  in_item,
  tcse_out_if.source out_item
);

  localparam int TOTAL  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int COL_W  = tcse_pkg::COL_W;
  localparam int ROW_W  = tcse_pkg::ROW_W;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  tcse_pkg::tcse_ctl_state_t state_r, state_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic [COL_W-1:0]          col_r, col_nxt;
  tcse_pkg::tcse_color_t     fill_r, fill_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [tcse_pkg::CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [tcse_pkg::COLOR_W-1:0]  out_fg_r, out_fg_nxt;
  logic [tcse_pkg::COLOR_W-1:0]  out_bg_r, out_bg_nxt;
  logic [ROW_W-1:0]              out_row_r, out_row_nxt;
  logic [COL_W-1:0]              out_col_r, out_col_nxt;
  logic                          out_oor_r, out_oor_nxt;

  tcse_pkg::tcse_op_t        op;
  tcse_pkg::tcse_store_cmd_t cmd;
  tcse_pkg::tcse_cell_t      put_cell;
  tcse_pkg::tcse_cell_t      rd_data;
  tcse_pkg::tcse_color_t     clear_color;
  logic                      store_busy;
  logic                      in_accept;
  logic                      is_newline;
  logic                      at_edge;
  logic                      read_oor;
  logic                      load;
  logic                      wr_en;
  logic                      rd_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [ADDR_W-1:0]         rd_addr;

  assign op         = tcse_pkg::tcse_op_t'(in_item.operation);
  assign in_item.ready = (state_r == tcse_pkg::CTL_IDLE) && !store_busy &&
                         (!out_valid_r || out_item.ready);
  assign in_accept  = in_item.valid && in_item.ready;
  assign is_newline = (in_item.char_code == tcse_pkg::NEWLINE_CODE);
  assign at_edge    = (col_r == COL_LAST);
  assign read_oor   = ({1'b0, in_item.cell_column} >= (COL_W + 1)'(COLUMNS)) ||
                      ({1'b0, in_item.cell_row} >= (ROW_W + 1)'(ROWS));

  assign put_cell.ch = in_item.char_code;
  assign put_cell.fg = in_item.fg_color;
  assign put_cell.bg = in_item.bg_color;
  assign clear_color.bg = in_item.bg_color;
  assign clear_color.fg = tcse_pkg::WHITE;

  assign wr_addr = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r));
  assign rd_addr = ADDR_W'(ADDR_W'(in_item.cell_row) * ADDR_W'(COLUMNS) +
                           ADDR_W'(in_item.cell_column));

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    fill_nxt      = fill_r;
    load          = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    cmd.start_fill   = 1'b0;
    cmd.start_scroll = 1'b0;
    cmd.fill_cell    = tcse_pkg::blank_cell(fill_r);
    out_char_nxt  = '0;
    out_fg_nxt    = '0;
    out_bg_nxt    = '0;
    out_oor_nxt   = 1'b0;
    unique case (state_r)
      tcse_pkg::CTL_IDLE: begin
        if (in_accept) begin
          load = 1'b1;
          unique case (op)
            tcse_pkg::OP_PUT: begin
              if (!is_newline) begin
                wr_en   = 1'b1;
                col_nxt = col_r + 1'b1;
              end
              if (is_newline || at_edge) begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  cmd.start_scroll = 1'b1;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end
            end
            tcse_pkg::OP_SET_FILL: begin
              fill_nxt.fg = in_item.fg_color;
              fill_nxt.bg = in_item.bg_color;
            end
            tcse_pkg::OP_CLEAR: begin
              fill_nxt       = clear_color;
              cmd.start_fill = 1'b1;
              cmd.fill_cell  = tcse_pkg::blank_cell(clear_color);
              row_nxt        = '0;
              col_nxt        = '0;
            end
            tcse_pkg::OP_READ: begin
              if (read_oor) begin
                out_oor_nxt = 1'b1;
              end else begin
                // hold the result until the store returns the cell
                load      = 1'b0;
                rd_en     = 1'b1;
                state_nxt = tcse_pkg::CTL_READ;
              end
            end
            default: load = 1'b0;
          endcase
        end
      end
      tcse_pkg::CTL_READ: begin
        load         = 1'b1;
        out_char_nxt = rd_data.ch;
        out_fg_nxt   = rd_data.fg;
        out_bg_nxt   = rd_data.bg;
        state_nxt    = tcse_pkg::CTL_IDLE;
      end
      default: state_nxt = tcse_pkg::CTL_IDLE;
    endcase
    out_row_nxt = row_nxt;
    out_col_nxt = col_nxt;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcse_pkg::CTL_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      fill_r      <= tcse_pkg::tcse_color_t'({tcse_pkg::BLACK, tcse_pkg::WHITE});
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= out_char_nxt;
      out_fg_r   <= out_fg_nxt;
      out_bg_r   <= out_bg_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_oor_r  <= out_oor_nxt;
    end
  end

  assign out_item.valid             = out_valid_r;
  assign out_item.read_char         = out_char_r;
  assign out_item.read_fg           = out_fg_r;
  assign out_item.read_bg           = out_bg_r;
  assign out_item.cursor_row_now    = out_row_r;
  assign out_item.cursor_column_now = out_col_r;
  assign out_item.out_of_range      = out_oor_r;

  tcse_cell_store #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cell_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (put_cell),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

endmodule

// ===== src/tcse_checker.sv =====
`timescale 1ns / 1ps

module tcse_checker #(
  parameter int COLUMNS = tcse_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcse_pkg::ROWS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [tcse_pkg::OP_W-1:0]     in_operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcse_pkg::CHAR_W-1:0]   out_read_char,
  input logic [tcse_pkg::COLOR_W-1:0]  out_read_fg,
  input logic [tcse_pkg::COLOR_W-1:0]  out_read_bg,
  input logic [tcse_pkg::ROW_W-1:0]    out_row,
  input logic [tcse_pkg::COL_W-1:0]    out_col,
  input logic                          out_of_range
);

  // the clearing pass keeps input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation != tcse_pkg::OP_READ) |=>
      (out_valid && !out_of_range))
    else $error("no result after non-read item");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_of_range) |->
      (out_read_char == '0 && out_read_fg == '0 && out_read_bg == '0))
    else $error("out of range read carries cell data");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_row) < ROWS && int'(out_col) < COLUMNS))
    else $error("cursor outside the store");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind text_console_scroll_engine tcse_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_item.valid),
  .in_ready      (in_item.ready),
  .in_operation  (in_item.operation),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .out_read_char (out_item.read_char),
  .out_read_fg   (out_item.read_fg),
  .out_read_bg   (out_item.read_bg),
  .out_row       (out_item.cursor_row_now),
  .out_col       (out_item.cursor_column_now),
  .out_of_range  (out_item.out_of_range)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tcse_pkg::*;

  localparam int SCREEN_COLS = COLUMNS_DEF;
  localparam int SCREEN_ROWS = ROWS_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int LONG_HOLD_CYCLES = 400;

  // kinds of random segments
  localparam int SEG_TEXT     = 0;
  localparam int SEG_READS    = 1;
  localparam int SEG_COLORS   = 2;
  localparam int SEG_NEWLINES = 3;
  localparam int SEG_NOISE    = 4;

  // receiver stall patterns
  localparam int RX_ALWAYS   = 0;
  localparam int RX_COIN     = 1;
  localparam int RX_SPARSE   = 2;
  localparam int RX_PERIODIC = 3;

  typedef struct packed {
    tcse_op_t           op;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
  } console_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  read_char;
    logic [COLOR_W-1:0] read_fg;
    logic [COLOR_W-1:0] read_bg;
    logic [ROW_W-1:0]   cursor_row_now;
    logic [COL_W-1:0]   cursor_column_now;
    logic               out_of_range;
  } console_result_t;

  typedef struct {
    console_cmd_t    cmd;
    int unsigned     reps;
    bit              typed;
    console_result_t want;
  } stim_row_t;

  localparam console_result_t NO_RESULT = '0;

  logic clk;
  logic rst_n;

  tcse_in_if  in_if ();
  tcse_out_if out_if ();

  text_console_scroll_engine uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if)
  );

  // screen model
  tcse_cell_t  screen [SCREEN_ROWS*SCREEN_COLS];
  int unsigned cur_row;
  int unsigned cur_col;
  tcse_color_t fill;

  console_result_t pending_results [$];
  stim_row_t       directed_rows [$];
  int unsigned     mismatches;
  int unsigned     burst_left;
  bit              long_hold_request;
  bit              long_hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #160000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_error(string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void scroll_screen();
    for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
      screen[i] = screen[i + SCREEN_COLS];
    for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_ROWS * SCREEN_COLS; i++)
      screen[i] = '{bg: fill.bg, fg: fill.fg, ch: BLANK_CODE};
  endfunction

  function automatic void next_line();
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCREEN_ROWS) begin
      scroll_screen();
      cur_row = SCREEN_ROWS - 1;
    end
  endfunction

  function automatic console_result_t apply_command(console_cmd_t c);
    console_result_t r;
    tcse_cell_t      entry;
    r = '0;
    case (c.op)
      OP_PUT: begin
        if (c.ch == NEWLINE_CODE) begin
          next_line();
        end else begin
          screen[cur_row * SCREEN_COLS + cur_col] = '{bg: c.bg, fg: c.fg, ch: c.ch};
          cur_col++;
          if (cur_col >= SCREEN_COLS) next_line();
        end
      end
      OP_SET_FILL: fill = '{bg: c.bg, fg: c.fg};
      OP_CLEAR: begin
        cur_row = 0;
        cur_col = 0;
        fill = '{bg: c.bg, fg: WHITE};
        foreach (screen[i]) screen[i] = '{bg: fill.bg, fg: fill.fg, ch: BLANK_CODE};
      end
      default: begin
        if (c.col >= SCREEN_COLS || c.row >= SCREEN_ROWS) begin
          r.out_of_range = 1'b1;
        end else begin
          entry = screen[int'(c.row) * SCREEN_COLS + int'(c.col)];
          r.read_char = entry.ch;
          r.read_fg = entry.fg;
          r.read_bg = entry.bg;
        end
      end
    endcase
    r.cursor_row_now = ROW_W'(cur_row);
    r.cursor_column_now = COL_W'(cur_col);
    return r;
  endfunction

  function automatic console_cmd_t random_command(int kind);
    console_cmd_t c;
    int           pick;
    c.op = tcse_op_t'($urandom_range(0, 3));
    c.ch = CHAR_W'($urandom);
    c.fg = COLOR_W'($urandom);
    c.bg = COLOR_W'($urandom);
    c.col = COL_W'($urandom);
    c.row = ROW_W'($urandom);
    pick = $urandom_range(0, 99);
    case (kind)
      SEG_TEXT, SEG_NEWLINES: begin
        if (pick < (kind == SEG_TEXT ? 85 : 80)) begin
          c.op = OP_PUT;
          if ($urandom_range(0, 99) < (kind == SEG_TEXT ? 15 : 45)) c.ch = NEWLINE_CODE;
        end else begin
          c.op = OP_READ;
        end
      end
      SEG_READS: begin
        if (pick < 10) c.op = OP_PUT;
        else c.op = OP_READ;
      end
      SEG_COLORS: begin
        if (pick < 30) c.op = OP_SET_FILL;
        else if (pick < 80) c.op = OP_PUT;
        else c.op = OP_READ;
      end
      default: begin
        // keep clears rare so the cursor gets a chance to reach the bottom
        if (c.op == OP_CLEAR && $urandom_range(0, 9) != 0) c.op = OP_READ;
      end
    endcase
    // aim most reads inside the screen, leave noise reads on full range
    if (c.op == OP_READ && kind != SEG_NOISE && $urandom_range(0, 99) < 88) begin
      c.col = COL_W'($urandom_range(0, SCREEN_COLS - 1));
      c.row = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
    end
    return c;
  endfunction

  task automatic send_command(console_cmd_t c, bit typed, console_result_t want);
    int              gap;
    console_result_t predicted;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid       <= 1'b1;
    in_if.operation   <= c.op;
    in_if.char_code   <= c.ch;
    in_if.fg_color    <= c.fg;
    in_if.bg_color    <= c.bg;
    in_if.cell_column <= c.col;
    in_if.cell_row    <= c.row;
    do @(posedge clk); while (!in_if.ready);
    predicted = apply_command(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    console_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_error("result item with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_if.read_char !== want.read_char)
          report_error($sformatf("read_char got %h want %h", out_if.read_char, want.read_char));
        if (out_if.read_fg !== want.read_fg)
          report_error($sformatf("read_fg got %h want %h", out_if.read_fg, want.read_fg));
        if (out_if.read_bg !== want.read_bg)
          report_error($sformatf("read_bg got %h want %h", out_if.read_bg, want.read_bg));
        if (out_if.cursor_row_now !== want.cursor_row_now)
          report_error($sformatf("cursor_row_now got %0d want %0d",
                                 out_if.cursor_row_now, want.cursor_row_now));
        if (out_if.cursor_column_now !== want.cursor_column_now)
          report_error($sformatf("cursor_column_now got %0d want %0d",
                                 out_if.cursor_column_now, want.cursor_column_now));
        if (out_if.out_of_range !== want.out_of_range)
          report_error($sformatf("out_of_range got %b want %b",
                                 out_if.out_of_range, want.out_of_range));
      end
    end
  end

  // receiver: shifting stall patterns plus one long hold-off
  initial begin : receiver
    int mode;
    int mode_left;
    int unsigned phase;
    mode = RX_ALWAYS;
    mode_left = 0;
    phase = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_request && !long_hold_done) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_ALWAYS:   out_if.ready <= 1'b1;
          RX_COIN:     out_if.ready <= 1'($urandom);
          RX_SPARSE:   out_if.ready <= ($urandom_range(0, 3) == 0);
          default:     out_if.ready <= phase[1];
        endcase
      end
    end
  end

  initial begin : stimulus
    console_cmd_t c;
    int           seg_kind;
    int           seg_left;
    mismatches = 0;
    burst_left = 0;
    long_hold_request = 1'b0;
    long_hold_done = 1'b0;
    cur_row = 0;
    cur_col = 0;
    fill = '{bg: BLACK, fg: WHITE};
    foreach (screen[i]) screen[i] = RESET_CELL;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operation = OP_PUT;
    in_if.char_code = '0;
    in_if.fg_color = '0;
    in_if.bg_color = '0;
    in_if.cell_column = '0;
    in_if.cell_row = '0;

    // op, ch, fg, bg, col, row; repeat count; typed; expected result
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd0}, 1, 1'b1,
                              '{8'h20, 4'hF, 4'h0, 5'd0, 7'd0, 1'b0}});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd79, 5'd24}, 1, 1'b1,
                              '{8'h20, 4'hF, 4'h0, 5'd0, 7'd0, 1'b0}});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd80, 5'd0}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b1}});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd25}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b1}});
    directed_rows.push_back('{'{OP_READ, 8'hFF, 4'hF, 4'hF, 7'd127, 5'd31}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b1}});
    directed_rows.push_back('{'{OP_SET_FILL, 8'h00, 4'h3, 4'h5, 7'd0, 5'd0}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0}});
    directed_rows.push_back('{'{OP_PUT, 8'h41, 4'h1, 4'h2, 7'd0, 5'd0}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd1, 1'b0}});
    directed_rows.push_back('{'{OP_PUT, 8'hFF, 4'hF, 4'hF, 7'd127, 5'd31}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd2, 1'b0}});
    directed_rows.push_back('{'{OP_PUT, 8'h00, 4'h0, 4'h0, 7'd0, 5'd0}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd3, 1'b0}});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd0}, 1, 1'b1,
                              '{8'h41, 4'h1, 4'h2, 5'd0, 7'd3, 1'b0}});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd1, 5'd0}, 1, 1'b1,
                              '{8'hFF, 4'hF, 4'hF, 5'd0, 7'd3, 1'b0}});
    directed_rows.push_back('{'{OP_PUT, NEWLINE_CODE, 4'h6, 4'h6, 7'd0, 5'd0}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd1, 7'd0, 1'b0}});
    directed_rows.push_back('{'{OP_CLEAR, 8'h00, 4'h0, 4'hF, 7'd0, 5'd0}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0}});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd5, 5'd5}, 1, 1'b1,
                              '{8'h20, 4'hF, 4'hF, 5'd0, 7'd0, 1'b0}});
    // fill a row up to the right edge, then wrap
    directed_rows.push_back('{'{OP_PUT, 8'h42, 4'h7, 4'h0, 7'd0, 5'd0}, 79, 1'b0, NO_RESULT});
    directed_rows.push_back('{'{OP_PUT, 8'h43, 4'h4, 4'h1, 7'd0, 5'd0}, 1, 1'b0, NO_RESULT});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd79, 5'd0}, 1, 1'b0, NO_RESULT});
    // walk down to the last row and scroll with a new fill colour
    directed_rows.push_back('{'{OP_PUT, NEWLINE_CODE, 4'h0, 4'h0, 7'd0, 5'd0}, 23, 1'b0,
                              NO_RESULT});
    directed_rows.push_back('{'{OP_SET_FILL, 8'h00, 4'h2, 4'h9, 7'd0, 5'd0}, 1, 1'b0,
                              NO_RESULT});
    directed_rows.push_back('{'{OP_PUT, NEWLINE_CODE, 4'h0, 4'h0, 7'd0, 5'd0}, 1, 1'b0,
                              NO_RESULT});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd79, 5'd24}, 1, 1'b0, NO_RESULT});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd23}, 1, 1'b0, NO_RESULT});
    // wrap off the last row
    directed_rows.push_back('{'{OP_PUT, 8'h44, 4'hA, 4'h5, 7'd0, 5'd0}, 80, 1'b0, NO_RESULT});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd79, 5'd23}, 1, 1'b0, NO_RESULT});
    directed_rows.push_back('{'{OP_READ, 8'h00, 4'h0, 4'h0, 7'd0, 5'd24}, 1, 1'b0, NO_RESULT});
    directed_rows.push_back('{'{OP_CLEAR, 8'h00, 4'h0, 4'h0, 7'd0, 5'd0}, 1, 1'b1,
                              '{8'h00, 4'h0, 4'h0, 5'd0, 7'd0, 1'b0}});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      for (int n = 0; n < directed_rows[i].reps; n++)
        send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    seg_left = 0;
    seg_kind = SEG_TEXT;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: seg_kind = SEG_TEXT;
          5, 6:          seg_kind = SEG_READS;
          7:             seg_kind = SEG_COLORS;
          8:             seg_kind = SEG_NEWLINES;
          default:       seg_kind = SEG_NOISE;
        endcase
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      // hold the receiver off once while items keep coming
      if (n == 150) long_hold_request = 1'b1;
      c = random_command(seg_kind);
      send_command(c, 1'b0, NO_RESULT);
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tcse_pkg.sv
src/tcse_in_if.sv
src/tcse_out_if.sv
src/tcse_cell_store.sv
src/text_console_scroll_engine.sv
src/tcse_checker.sv
sim/tb_top.sv
